### rtl/core/mfp_pkg.sv
// Shared types, character codes and helper functions for the format printer.
package mfp_pkg;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_LC_C    = 8'h63;
	localparam logic [7:0] CH_UC_X    = 8'h58;
	localparam logic [7:0] CH_LC_X    = 8'h78;
	localparam logic [7:0] CH_LC_D    = 8'h64;
	localparam logic [7:0] ASCII_ZERO = 8'h30;

	localparam int unsigned CNT_W     = 7;
	localparam logic [CNT_W-1:0] CNT_SAT = '1;

	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QPTR_W    = $clog2(QDEPTH);

	localparam int unsigned DEC_DIGITS = 5;
	localparam logic [2:0] DEC_LAST   = 3'(DEC_DIGITS - 1);

	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_HEX,
		CMD_DEC
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        upper;
		logic [15:0] value;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  digit;
		logic [15:0] rem;
	} dec_step_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = ASCII_ZERO + 8'(nib);
		end else if (upper) begin
			c = 8'h41 + 8'(nib - 4'd10);
		end else begin
			c = 8'h61 + 8'(nib - 4'd10);
		end
		return c;
	endfunction

	// Power of ten for a digit position, most significant first.
	function automatic logic [16:0] pow10(input logic [2:0] pos);
		logic [16:0] p;
		case (pos)
			3'd0: p = 17'd10000;
			3'd1: p = 17'd1000;
			3'd2: p = 17'd100;
			3'd3: p = 17'd10;
			default: p = 17'd1;
		endcase
		return p;
	endfunction

	// One decimal digit: compare against all multiples in parallel, take the largest.
	function automatic dec_step_t dec_step(input logic [15:0] cur, input logic [2:0] pos);
		dec_step_t r;
		logic [16:0] p;
		logic [16:0] sub;
		p     = pow10(pos);
		r.digit = 4'd0;
		sub   = '0;
		for (int d = 1; d <= 9; d++) begin
			if ({1'b0, cur} >= 17'(d) * p) begin
				r.digit = 4'(d);
				sub     = 17'(d) * p;
			end
		end
		r.rem = 16'({1'b0, cur} - sub);
		return r;
	endfunction

endpackage

### rtl/core/mfp_in_if.sv
// Input channel: one format character with its value and start mark per item.
interface mfp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  fmt_char;
	logic [15:0] value_in;
	logic        first_char;

	modport source (output valid, output fmt_char, output value_in, output first_char,
		input ready);
	modport sink (input valid, input fmt_char, input value_in, input first_char,
		output ready);
endinterface

### rtl/core/mfp_out_if.sv
// Output channel: one emitted character per item.
interface mfp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

### rtl/core/mini_format_printer.sv
// Top level of the format printer: front end, command queue and print sequencer.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+-------------------------------------------
//  in_ch   | in  | valid/ready  | fmt_char[7:0], value_in[15:0], first_char
//  out_ch  | out | valid/ready  | out_byte[7:0], last_of_run
//
//  An input item is taken every cycle while the four-entry command queue has
//  room; plain characters leave at one item per cycle while the output is not
//  stalled, through the queue and the registered output. Hex runs emit two
//  characters; decimal runs take one sequencer step per digit position (five
//  positions, the suppressed leading zeros included). Reset clears parse state,
//  queue pointers and the output valid; the string starts out ended. A stalled
//  output holds its item and backs up the queue, and a full queue drops in_ch.ready.
module mini_format_printer #(
	parameter int MAX_CHARS = 100
) (
	input  logic      clk,
	input  logic      arst_n,
	mfp_in_if.sink    in_ch,
	mfp_out_if.source out_ch
);

	// Commands from the front end; characters that print nothing never enter.
	logic          push;
	mfp_pkg::cmd_t push_cmd;
	logic          q_full;

	// Head of the queue as seen by the sequencer.
	logic          head_valid;
	mfp_pkg::cmd_t head;
	logic          pop;

	// Parse each character, update string state, classify into a command.
	mfp_front #(
		.MAX_CHARS (MAX_CHARS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push),
		.cmd    (push_cmd)
	);

	// Decouple parsing from printing so multi-character runs do not stall input at once.
	mfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// Expand each command into characters behind a registered output.
	mfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

### rtl/core/mfp_front.sv
// Front end: parse state and classification of each character into a print command.
module mfp_front #(
	parameter int MAX_CHARS = 100
) (
	input  logic            clk,
	input  logic            arst_n,
	mfp_in_if.sink          in_ch,
	input  logic            q_full,
	output logic            push,
	output mfp_pkg::cmd_t   cmd
);

	localparam logic [mfp_pkg::CNT_W-1:0] MaxCnt = mfp_pkg::CNT_W'(MAX_CHARS);

	logic [15:0]               held_q, held_d;
	logic                      pend_q, pend_d;
	logic [mfp_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic                      ended_q, ended_d;
	logic                      acc;
	logic                      gen;

	assign in_ch.ready = !q_full;
	assign acc         = in_ch.valid && in_ch.ready;
	assign push        = acc && gen;

	always_comb begin
		held_d  = held_q;
		pend_d  = pend_q;
		cnt_d   = cnt_q;
		ended_d = ended_q;
		gen     = 1'b0;
		cmd.kind  = mfp_pkg::CMD_BYTE;
		cmd.upper = 1'b0;
		cmd.value = '0;
		if (in_ch.first_char) begin
			held_d  = in_ch.value_in;
			pend_d  = 1'b0;
			cnt_d   = '0;
			ended_d = 1'b0;
		end
		if (!ended_d) begin
			if (in_ch.fmt_char == mfp_pkg::CH_NUL) begin
				ended_d = 1'b1;
				pend_d  = 1'b0;
			end else if (!pend_d && cnt_d >= MaxCnt) begin
				ended_d = 1'b1;
			end else begin
				if (cnt_d != mfp_pkg::CNT_SAT) begin
					cnt_d = cnt_d + 1'b1;
				end
				if (pend_d) begin
					pend_d = 1'b0;
					case (in_ch.fmt_char)
						mfp_pkg::CH_LC_C: begin
							gen       = 1'b1;
							cmd.kind  = mfp_pkg::CMD_BYTE;
							cmd.value = {8'h00, held_d[7:0]};
						end
						mfp_pkg::CH_UC_X: begin
							gen       = 1'b1;
							cmd.kind  = mfp_pkg::CMD_HEX;
							cmd.upper = 1'b1;
							cmd.value = {8'h00, held_d[7:0]};
						end
						mfp_pkg::CH_LC_X: begin
							gen       = 1'b1;
							cmd.kind  = mfp_pkg::CMD_HEX;
							cmd.value = {8'h00, held_d[7:0]};
						end
						mfp_pkg::CH_LC_D: begin
							gen       = 1'b1;
							cmd.kind  = mfp_pkg::CMD_DEC;
							cmd.value = held_d;
							held_d    = '0;
						end
						default: begin
							gen = 1'b0;
						end
					endcase
				end else if (in_ch.fmt_char == mfp_pkg::CH_PERCENT) begin
					pend_d = 1'b1;
				end else begin
					gen       = 1'b1;
					cmd.value = {8'h00, in_ch.fmt_char};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			pend_q  <= 1'b0;
			cnt_q   <= '0;
			ended_q <= 1'b1;
		end else if (acc) begin
			held_q  <= held_d;
			pend_q  <= pend_d;
			cnt_q   <= cnt_d;
			ended_q <= ended_d;
		end
	end

endmodule

### rtl/core/mfp_queue.sv
// Short command queue between the front end and the print sequencer.
module mfp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mfp_pkg::cmd_t   push_cmd,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output mfp_pkg::cmd_t   head
);

	mfp_pkg::cmd_t                mem_q [mfp_pkg::QDEPTH];
	logic [mfp_pkg::QPTR_W-1:0]   wr_q, rd_q;
	logic [mfp_pkg::QPTR_W:0]     cnt_q;

	assign full       = cnt_q == (mfp_pkg::QPTR_W+1)'(mfp_pkg::QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/core/mfp_back.sv
// Print sequencer: expands queued commands into characters, at most one per cycle while the output is not stalled.
module mfp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  mfp_pkg::cmd_t   head,
	output logic            pop,
	mfp_out_if.source       out_ch
);

	logic [2:0]          step_q;
	logic [15:0]         rem_q;
	logic                started_q;
	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                out_last_q;

	logic                adv, fire, emit, done;
	logic [7:0]          byte_c;
	logic [15:0]         cur;
	logic [3:0]          nib;
	mfp_pkg::dec_step_t  ds;

	assign adv  = !out_valid_q || out_ch.ready;
	assign fire = adv && head_valid;
	assign pop  = fire && done;
	assign cur  = (step_q == '0) ? head.value : rem_q;
	assign nib  = step_q[0] ? head.value[3:0] : head.value[7:4];
	assign ds   = mfp_pkg::dec_step(cur, step_q);

	always_comb begin
		emit   = 1'b1;
		done   = 1'b1;
		byte_c = head.value[7:0];
		case (head.kind)
			mfp_pkg::CMD_BYTE: begin
				emit   = 1'b1;
				done   = 1'b1;
				byte_c = head.value[7:0];
			end
			mfp_pkg::CMD_HEX: begin
				emit   = 1'b1;
				done   = step_q[0];
				byte_c = mfp_pkg::hex_char(nib, head.upper);
			end
			mfp_pkg::CMD_DEC: begin
				done   = step_q == mfp_pkg::DEC_LAST;
				emit   = started_q || ds.digit != 4'd0 || done;
				byte_c = mfp_pkg::ASCII_ZERO + 8'(ds.digit);
			end
			default: begin
				emit = 1'b0;
				done = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= fire && emit;
			if (fire) begin
				step_q    <= done ? '0 : step_q + 1'b1;
				started_q <= done ? 1'b0 : (started_q || emit);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rem_q      <= ds.rem;
			out_byte_q <= byte_c;
			out_last_q <= done;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_byte    = out_byte_q;
	assign out_ch.last_of_run = out_last_q;

endmodule

### rtl/core/mfp_checker.sv
// Port-level checks for the format printer, bound to the top level.
module mfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);

	logic seen_in_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_in_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			seen_in_q <= 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
		else $error("output payload changed while stalled");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("gap inside a character run");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_in_q)
		else $error("output item with no input accepted");

endmodule

bind mini_format_printer mfp_checker u_mfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.out_last  (out_ch.last_of_run)
);
